@@ sv/rcf_pkg.sv @@
// rcf_pkg: shared widths, register codes, hop table and helpers for the rc frame builder
package rcf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CHAN_W    = 7;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned HOP_W     = 5;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ROW_LEN   = 16;
  localparam int unsigned NUM_ROWS  = 4;

  localparam logic [BYTE_W-1:0] BIND_FLAGS = 8'hC0;
  localparam logic [BYTE_W-1:0] PAD_VALUE  = 8'h40;
  localparam logic [POS_W-1:0]  LAST_POS   = 4'd15;

  localparam logic [BYTE_W-1:0] ID0_RESET = 8'd177;
  localparam logic [BYTE_W-1:0] ID1_RESET = 8'd9;
  localparam logic [BYTE_W-1:0] ID2_RESET = 8'd156;

  typedef enum logic [1:0] {
    REG_ID_ZERO = 2'd0,
    REG_ID_ONE  = 2'd1,
    REG_ID_TWO  = 2'd2
  } reg_index_t;

  // frame byte positions with a fixed meaning
  typedef enum logic [POS_W-1:0] {
    POS_THROTTLE = 4'd0,
    POS_YAW      = 4'd1,
    POS_PITCH    = 4'd2,
    POS_ROLL     = 4'd4,
    POS_PAD_A    = 4'd5,
    POS_PAD_B    = 4'd6,
    POS_ID_ZERO  = 4'd7,
    POS_ID_ONE   = 4'd8,
    POS_ID_TWO   = 4'd9,
    POS_FLAGS    = 4'd14,
    POS_SUM      = 4'd15
  } frame_pos_t;

  // four hop rows, row-major
  localparam logic [CHAN_W-1:0] HOP_ROWS [NUM_ROWS*ROW_LEN] = '{
    7'h27, 7'h1B, 7'h39, 7'h28, 7'h24, 7'h22, 7'h2E, 7'h36,
    7'h19, 7'h21, 7'h29, 7'h14, 7'h1E, 7'h12, 7'h2D, 7'h18,
    7'h2E, 7'h33, 7'h25, 7'h38, 7'h19, 7'h12, 7'h18, 7'h16,
    7'h2A, 7'h1C, 7'h1F, 7'h37, 7'h2F, 7'h23, 7'h34, 7'h10,
    7'h11, 7'h1A, 7'h35, 7'h24, 7'h28, 7'h18, 7'h25, 7'h2A,
    7'h32, 7'h2C, 7'h14, 7'h27, 7'h36, 7'h34, 7'h1C, 7'h17,
    7'h22, 7'h27, 7'h17, 7'h39, 7'h34, 7'h28, 7'h2B, 7'h1D,
    7'h18, 7'h2A, 7'h21, 7'h38, 7'h10, 7'h26, 7'h20, 7'h1F
  };

  // channel for one hop slot; only the low five bits of the id sum matter
  function automatic logic [CHAN_W-1:0] hop_channel(
    input logic [BYTE_W-1:0] id0,
    input logic [BYTE_W-1:0] id1,
    input logic [BYTE_W-1:0] id2,
    input logic [POS_W-1:0]  slot
  );
    logic [4:0]        s;
    logic [1:0]        row;
    logic [2:0]        offset;
    logic [CHAN_W-1:0] v;
    s      = id0[4:0] + id1[4:0] + id2[4:0];
    row    = s[1:0];
    offset = s[4:2];
    v      = HOP_ROWS[{row, slot}] + CHAN_W'(offset);
    if (v[3:0] == 4'd0) begin
      v = v - CHAN_W'(3);
    end
    return v;
  endfunction

endpackage

@@ sv/rcf_if.sv @@
// rcf_if: command and frame-byte channel interfaces
interface rcf_cmd_if;
  import rcf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] throttle;
  logic [BYTE_W-1:0] yaw;
  logic [BYTE_W-1:0] pitch;
  logic [BYTE_W-1:0] roll;
  logic [BYTE_W-1:0] mode_flags;

  modport source (output valid, throttle, yaw, pitch, roll, mode_flags, input ready);
  modport sink   (input valid, throttle, yaw, pitch, roll, mode_flags, output ready);
endinterface

interface rcf_byte_if;
  import rcf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] rf_channel;
  logic [POS_W-1:0]  byte_position;
  logic [BYTE_W-1:0] payload_byte;
  logic              last_byte;

  modport source (output valid, rf_channel, byte_position, payload_byte, last_byte,
                  input ready);
  modport sink   (input valid, rf_channel, byte_position, payload_byte, last_byte,
                  output ready);
endinterface

@@ sv/rc_frame_builder_channel_hopping.sv @@
// rc_frame_builder_channel_hopping: turns control commands into 16-byte hopping radio frames
// Each command word on cmd becomes sixteen words on frame, bytes 0 to 15 in order, all
// tagged with the frame's radio channel; byte 15 is the checksum and carries last_byte.
// The byte serializer sets the pace at which commands are taken. A command is taken
// into a holding register while the previous frame is still going out, so back-to-back
// frames leave without a gap. The channel is picked from the hop table when the command
// is taken, and the hop counter steps once per command, so each hop slot serves two
// consecutive frames. Identifier registers sit on the APB port at 0x0, 0x4 and 0x8;
// change them only while no frame is in flight.
module rc_frame_builder_channel_hopping (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcf_pkg::ADDR_W-1:0] paddr,
  input  logic [rcf_pkg::DATA_W-1:0] pwdata,
  output logic [rcf_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  rcf_cmd_if.sink                    cmd,
  rcf_byte_if.source                 frame
);
  import rcf_pkg::*;

  logic [BYTE_W-1:0] id_byte_zero;
  logic [BYTE_W-1:0] id_byte_one;
  logic [BYTE_W-1:0] id_byte_two;
  logic [HOP_W-1:0]  hop_counter;
  reg_index_t        reg_sel;

  // holding stage
  logic              h_valid;
  logic [BYTE_W-1:0] h_throttle;
  logic [BYTE_W-1:0] h_yaw;
  logic [BYTE_W-1:0] h_pitch;
  logic [BYTE_W-1:0] h_roll;
  logic [BYTE_W-1:0] h_flags;
  logic [CHAN_W-1:0] h_channel;

  // serializing stage
  logic              f_valid;
  logic [BYTE_W-1:0] f_throttle;
  logic [BYTE_W-1:0] f_yaw;
  logic [BYTE_W-1:0] f_pitch;
  logic [BYTE_W-1:0] f_roll;
  logic [BYTE_W-1:0] f_pad;
  logic [BYTE_W-1:0] f_flags;
  logic [BYTE_W-1:0] f_sum;
  logic [CHAN_W-1:0] f_channel;
  logic [POS_W-1:0]  f_pos;

  // output register
  logic              o_valid;
  logic [CHAN_W-1:0] o_channel;
  logic [POS_W-1:0]  o_pos;
  logic [BYTE_W-1:0] o_byte;
  logic              o_last;

  logic              cmd_acc;
  logic              out_load;
  logic              f_done;
  logic              f_load;
  logic              h_bind;
  logic [BYTE_W-1:0] h_sum;
  logic [BYTE_W-1:0] cur_byte;
  logic              cfg_wr;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      id_byte_zero <= ID0_RESET;
      id_byte_one  <= ID1_RESET;
      id_byte_two  <= ID2_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ID_ZERO: id_byte_zero <= pwdata[BYTE_W-1:0];
        REG_ID_ONE:  id_byte_one  <= pwdata[BYTE_W-1:0];
        REG_ID_TWO:  id_byte_two  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ID_ZERO: prdata = DATA_W'(id_byte_zero);
      REG_ID_ONE:  prdata = DATA_W'(id_byte_one);
      REG_ID_TWO:  prdata = DATA_W'(id_byte_two);
      default:     prdata = '0;
    endcase
  end

  // handshake control
  assign out_load  = f_valid && (!o_valid || frame.ready);
  assign f_done    = out_load && (f_pos == LAST_POS);
  assign f_load    = h_valid && (!f_valid || f_done);
  assign cmd.ready = !h_valid || f_load;
  assign cmd_acc   = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_counter <= '0;
      h_valid     <= 1'b0;
    end else begin
      if (cmd_acc) begin
        hop_counter <= hop_counter + HOP_W'(1);
      end
      if (cmd_acc) begin
        h_valid <= 1'b1;
      end else if (f_load) begin
        h_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      h_throttle <= cmd.throttle;
      h_yaw      <= cmd.yaw;
      h_pitch    <= cmd.pitch;
      h_roll     <= cmd.roll;
      h_flags    <= cmd.mode_flags;
      h_channel  <= hop_channel(id_byte_zero, id_byte_one, id_byte_two,
                                hop_counter[HOP_W-1:1]);
    end
  end

  // bind frames zero the control bytes and the pads
  assign h_bind = (h_flags == BIND_FLAGS);

  always_comb begin
    h_sum = h_flags + id_byte_zero + id_byte_one + id_byte_two;
    if (!h_bind) begin
      h_sum = h_sum + h_throttle + h_yaw + h_pitch + h_roll + PAD_VALUE + PAD_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      f_pos   <= '0;
    end else if (f_load) begin
      f_valid <= 1'b1;
      f_pos   <= '0;
    end else if (f_done) begin
      f_valid <= 1'b0;
      f_pos   <= '0;
    end else if (out_load) begin
      f_pos   <= f_pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (f_load) begin
      f_throttle <= h_bind ? '0 : h_throttle;
      f_yaw      <= h_bind ? '0 : h_yaw;
      f_pitch    <= h_bind ? '0 : h_pitch;
      f_roll     <= h_bind ? '0 : h_roll;
      f_pad      <= h_bind ? '0 : PAD_VALUE;
      f_flags    <= h_flags;
      f_sum      <= h_sum;
      f_channel  <= h_channel;
    end
  end

  always_comb begin
    unique case (f_pos)
      POS_THROTTLE:           cur_byte = f_throttle;
      POS_YAW:                cur_byte = f_yaw;
      POS_PITCH:              cur_byte = f_pitch;
      POS_ROLL:               cur_byte = f_roll;
      POS_PAD_A, POS_PAD_B:   cur_byte = f_pad;
      POS_ID_ZERO:            cur_byte = id_byte_zero;
      POS_ID_ONE:             cur_byte = id_byte_one;
      POS_ID_TWO:             cur_byte = id_byte_two;
      POS_FLAGS:              cur_byte = f_flags;
      POS_SUM:                cur_byte = f_sum;
      default:                cur_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (frame.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_channel <= f_channel;
      o_pos     <= f_pos;
      o_byte    <= cur_byte;
      o_last    <= (f_pos == LAST_POS);
    end
  end

  assign frame.valid         = o_valid;
  assign frame.rf_channel    = o_channel;
  assign frame.byte_position = o_pos;
  assign frame.payload_byte  = o_byte;
  assign frame.last_byte     = o_last;

  // a freshly loaded frame starts at byte 0
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    f_load |=> f_valid && (f_pos == '0))
    else $error("frame load did not restart at byte 0");

  // byte position only moves when a word is handed to the output register
  a_pos_holds: assert property (@(posedge clk) disable iff (rst)
    f_valid && !out_load && !f_load |=> $stable(f_pos))
    else $error("byte position moved without an output load");

  // hop counter steps only on a taken command
  a_hop_steps: assert property (@(posedge clk) disable iff (rst)
    !cmd_acc |=> $stable(hop_counter))
    else $error("hop counter changed without a command");

  // the serializer empties after the checksum byte when nothing is waiting
  a_frame_drains: assert property (@(posedge clk) disable iff (rst)
    f_done && !h_valid |=> !f_valid)
    else $error("serializer still busy after last byte");

endmodule

@@ tb/sv/rcf_frame_checker.sv @@
// rcf_frame_checker: watches the command, frame and apb ports, predicts every frame word and compares
`timescale 1ns / 100ps

module rcf_frame_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [rcf_pkg::ADDR_W-1:0] paddr,
  input  logic [rcf_pkg::DATA_W-1:0] pwdata,
  input  logic [rcf_pkg::DATA_W-1:0] prdata,
  rcf_cmd_if                         cmd,
  rcf_byte_if                        frame,
  output int                         bytes_due,
  output int                         words_checked,
  output int                         mismatches
);
  import rcf_pkg::*;

  typedef struct packed {
    logic [6:0] channel;
    logic [3:0] pos;
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  localparam logic [7:0] PAD_BYTE = 8'h40;
  localparam logic [7:0] ID0_AFTER_RESET = 8'd177;
  localparam logic [7:0] ID1_AFTER_RESET = 8'd9;
  localparam logic [7:0] ID2_AFTER_RESET = 8'd156;

  // four rows of sixteen base channels, entry n at bits [511-8n -: 8]
  localparam logic [511:0] HOP_TABLE = {
    128'h271B3928_24222E36_19212914_1E122D18,
    128'h2E332538_19121816_2A1C1F37_2F233410,
    128'h111A3524_2818252A_322C1427_36341C17,
    128'h22271739_34282B1D_182A2138_1026201F
  };

  logic [7:0]  id_zero;
  logic [7:0]  id_one;
  logic [7:0]  id_two;
  logic [4:0]  hop_count;
  frame_word_t frame_words_due[$];

  function automatic logic [6:0] hop_lookup(input logic [3:0] slot);
    logic [9:0] id_sum;
    logic [7:0] entry;
    id_sum = 10'(id_zero) + 10'(id_one) + 10'(id_two);
    entry  = HOP_TABLE[511 - 8 * int'({id_sum[1:0], slot}) -: 8] + 8'(id_sum[4:2]);
    // a channel landing on a multiple of 16 is pulled down by three
    if (entry[3:0] == 4'd0) begin
      entry = entry - 8'd3;
    end
    return entry[6:0];
  endfunction

  task automatic build_frame(input logic [7:0] throttle, input logic [7:0] yaw,
                             input logic [7:0] pitch, input logic [7:0] roll,
                             input logic [7:0] flags);
    logic [7:0]  bytes [16];
    logic [7:0]  sum;
    logic [6:0]  channel;
    frame_word_t w;
    if (flags == BIND_FLAGS) begin
      for (int k = 0; k < 7; k++) bytes[k] = 8'd0;
    end else begin
      bytes[0] = throttle;
      bytes[1] = yaw;
      bytes[2] = pitch;
      bytes[3] = 8'd0;
      bytes[4] = roll;
      bytes[5] = PAD_BYTE;
      bytes[6] = PAD_BYTE;
    end
    bytes[7] = id_zero;
    bytes[8] = id_one;
    bytes[9] = id_two;
    for (int k = 10; k < 14; k++) bytes[k] = 8'd0;
    bytes[14] = flags;
    sum = 8'd0;
    for (int k = 0; k < 15; k++) sum = sum + bytes[k];
    bytes[15] = sum;
    channel   = hop_lookup(hop_count[4:1]);
    hop_count = hop_count + 5'd1;
    for (int k = 0; k < 16; k++) begin
      w.channel = channel;
      w.pos     = 4'(k);
      w.data    = bytes[k];
      w.last    = (k == 15);
      frame_words_due.push_back(w);
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch @%0t: %s", $realtime, msg);
    end
  endtask

  initial begin
    mismatches    = 0;
    words_checked = 0;
    bytes_due     = 0;
  end

  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    logic [7:0]  reg_val;
    logic        reg_hit;
    if (rst) begin
      id_zero   = ID0_AFTER_RESET;
      id_one    = ID1_AFTER_RESET;
      id_two    = ID2_AFTER_RESET;
      hop_count = 5'd0;
      frame_words_due.delete();
    end else begin
      if (psel && penable && pready) begin
        reg_hit = 1'b1;
        reg_val = 8'd0;
        case (paddr[3:2])
          REG_ID_ZERO: reg_val = id_zero;
          REG_ID_ONE:  reg_val = id_one;
          REG_ID_TWO:  reg_val = id_two;
          default:     reg_hit = 1'b0;
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_ID_ZERO: id_zero = pwdata[7:0];
            REG_ID_ONE:  id_one  = pwdata[7:0];
            REG_ID_TWO:  id_two  = pwdata[7:0];
            default: ;  // spare address, write dropped
          endcase
        end else if (reg_hit && prdata[7:0] !== reg_val) begin
          flag_mismatch($sformatf("read addr %0h expected %02h got %02h",
                                  paddr, reg_val, prdata[7:0]));
        end
      end
      if (cmd.valid && cmd.ready) begin
        build_frame(cmd.throttle, cmd.yaw, cmd.pitch, cmd.roll, cmd.mode_flags);
      end
      if (frame.valid && frame.ready) begin
        got = '{frame.rf_channel, frame.byte_position, frame.payload_byte, frame.last_byte};
        words_checked++;
        if (frame_words_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected word ch=%02h pos=%0d data=%02h last=%0b",
                                  got.channel, got.pos, got.data, got.last));
        end else begin
          want = frame_words_due.pop_front();
          if (got !== want) begin
            flag_mismatch($sformatf(
              "expected ch=%02h pos=%0d data=%02h last=%0b, got ch=%02h pos=%0d data=%02h last=%0b",
              want.channel, want.pos, want.data, want.last,
              got.channel, got.pos, got.data, got.last));
          end
        end
      end
    end
    bytes_due <= frame_words_due.size();
  end

endmodule

@@ tb/sv/rc_frame_builder_channel_hopping_tb.sv @@
// rc_frame_builder_channel_hopping_tb: clock, reset, command and apb stimulus, frame sink and verdict
`timescale 1ns / 100ps

module rc_frame_builder_channel_hopping_tb;
  import rcf_pkg::*;

  typedef struct packed {
    logic [7:0] throttle;
    logic [7:0] yaw;
    logic [7:0] pitch;
    logic [7:0] roll;
    logic [7:0] mode_flags;
  } stick_cmd_t;

  localparam int          CYCLE_LIMIT  = 2000000;
  localparam int          LONG_HOLD    = 300;
  localparam int          PHASES       = 8;
  localparam int          PHASE_CMDS   = 60;
  localparam logic [3:0]  ADDR_SPARE   = 4'hC;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int bytes_due;
  int words_checked;
  int mismatches;
  int cycle_count;
  int commands_sent;
  int bind_frames;
  int id_settings;

  logic source_gaps;
  logic sink_stalls;
  logic hold_frames;

  rcf_cmd_if  cmd_ch ();
  rcf_byte_if frame_ch ();

  rc_frame_builder_channel_hopping u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_ch),
    .frame   (frame_ch)
  );

  rcf_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .cmd           (cmd_ch),
    .frame         (frame_ch),
    .bytes_due     (bytes_due),
    .words_checked (words_checked),
    .mismatches    (mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, bytes_due);
      $display("FAIL");
      $finish;
    end
  end

  // mostly zero, sometimes short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stick_cmd_t random_command();
    stick_cmd_t  c;
    int unsigned r;
    c = {$urandom, 8'($urandom)};
    r = $urandom_range(0, 99);
    if (r < 15) begin
      c.mode_flags = BIND_FLAGS;
    end else if (r < 22) begin
      c.mode_flags = BIND_FLAGS ^ (8'd1 << $urandom_range(0, 7));
    end
    if ($urandom_range(0, 9) == 0) c.throttle = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 9) == 0) c.roll     = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return c;
  endfunction

  task automatic offer_command(input stick_cmd_t c);
    int unsigned gap;
    gap = source_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      cmd_ch.valid    <= 1'b0;
      cmd_ch.throttle <= 8'($urandom);
      cmd_ch.mode_flags <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.throttle   <= c.throttle;
    cmd_ch.yaw        <= c.yaw;
    cmd_ch.pitch      <= c.pitch;
    cmd_ch.roll       <= c.roll;
    cmd_ch.mode_flags <= c.mode_flags;
    do @(posedge clk); while (!cmd_ch.ready);
    commands_sent++;
    if (c.mode_flags == BIND_FLAGS) bind_frames++;
  endtask

  // stop offering and let every outstanding frame word drain
  task automatic drain_frames();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (bytes_due != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [3:0] addr,
                            input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_back_ids();
    apb_access(1'b0, {REG_ID_ZERO, 2'b00}, 32'd0);
    apb_access(1'b0, {REG_ID_ONE, 2'b00}, 32'd0);
    apb_access(1'b0, {REG_ID_TWO, 2'b00}, 32'd0);
  endtask

  // upper data bits are noise; only the low byte lands in a register
  task automatic set_ids(input logic [7:0] id0, input logic [7:0] id1, input logic [7:0] id2);
    apb_access(1'b1, {REG_ID_ZERO, 2'b00}, {24'($urandom), id0});
    apb_access(1'b1, {REG_ID_ONE, 2'b00}, {24'($urandom), id1});
    apb_access(1'b1, {REG_ID_TWO, 2'b00}, {24'($urandom), id2});
    if ($urandom_range(0, 2) == 0) apb_access(1'b1, ADDR_SPARE, $urandom);
    read_back_ids();
    id_settings++;
  endtask

  // frame sink: random stalls, plus a long hold when asked
  initial begin : frame_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_frames) begin
        frame_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_frames = 1'b0;
      end else if (stall_left > 0) begin
        frame_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
        frame_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        frame_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] ids [3];
    clk               = 1'b0;
    rst               = 1'b1;
    cycle_count       = 0;
    commands_sent     = 0;
    bind_frames       = 0;
    id_settings       = 1;
    source_gaps       = 1'b0;
    sink_stalls       = 1'b0;
    hold_frames       = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = 4'd0;
    pwdata            = 32'd0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.throttle   = 8'd0;
    cmd_ch.yaw        = 8'd0;
    cmd_ch.pitch      = 8'd0;
    cmd_ch.roll       = 8'd0;
    cmd_ch.mode_flags = 8'd0;
    frame_ch.ready    = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // identifiers straight out of reset
    read_back_ids();
    offer_command('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    offer_command('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    offer_command('{8'hFF, 8'hFF, 8'hFF, 8'hFF, BIND_FLAGS});
    offer_command('{8'h80, 8'h7F, 8'h01, 8'hFE, BIND_FLAGS ^ 8'h01});
    offer_command('{8'h55, 8'hAA, 8'h33, 8'hCC, BIND_FLAGS ^ 8'h80});
    offer_command('{8'hA5, 8'h5A, 8'hF0, 8'h0F, 8'h40});
    drain_frames();

    set_ids(8'h00, 8'h00, 8'h00);
    apb_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF);
    read_back_ids();
    offer_command('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h3F});
    offer_command('{8'h00, 8'h00, 8'h00, 8'h00, BIND_FLAGS});
    offer_command('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE});
    drain_frames();

    set_ids(8'hFF, 8'hFF, 8'hFF);
    offer_command('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    offer_command('{8'h01, 8'h02, 8'h04, 8'h08, BIND_FLAGS});
    offer_command('{8'h10, 8'h20, 8'h40, 8'h80, 8'h00});

    // long sink hold while commands keep coming, so the input backs up
    hold_frames = 1'b1;
    repeat (6) offer_command(random_command());
    drain_frames();

    for (int phase = 0; phase < PHASES; phase++) begin
      for (int k = 0; k < 3; k++) begin
        ids[k] = (phase % 4 == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
      end
      set_ids(ids[0], ids[1], ids[2]);
      source_gaps = (phase % 3 != 2);
      sink_stalls = (phase % 3 != 1);
      repeat (PHASE_CMDS) offer_command(random_command());
      drain_frames();
    end

    while (bytes_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("sent %0d commands (%0d bind frames) under %0d identifier settings",
             commands_sent, bind_frames, id_settings);
    $display("checked %0d frame words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rcf_pkg.sv
sv/rcf_if.sv
sv/rc_frame_builder_channel_hopping.sv
tb/sv/rcf_frame_checker.sv
tb/sv/rc_frame_builder_channel_hopping_tb.sv
